>>> rtl/spiral_matrix_fill_top_defines.svh
// -----------------------------------------------------------------------------
// Spiral matrix fill assertion macros
// Shared concurrent assertion forms for the spiral matrix fill block.
// -----------------------------------------------------------------------------
`ifndef SPIRAL_MATRIX_FILL_TOP_DEFINES_SVH
`define SPIRAL_MATRIX_FILL_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SMF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spiral fill: implication check failed");

// antecedent holds -> consequent holds in the next cycle
`define SMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spiral fill: next-cycle check failed");

// expression never holds
`define SMF_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("spiral fill: forbidden condition seen");

`endif

>>> rtl/smf_pkg.sv
// -----------------------------------------------------------------------------
// Spiral matrix fill package
// Types and constants shared by the spiral fill walk and top level.
// -----------------------------------------------------------------------------
package smf_pkg;

   localparam int DIM_W   = 11;   // rows / cols register width
   localparam int POS_W   = 10;   // row / column field width
   localparam int VALUE_W = 10;
   localparam int DATA_W  = 11;   // signed cell data
   localparam int WALK_W  = 12;   // signed walk coordinates and bounds
   localparam int FULL_W  = 21;   // r*cols + c before range check
   localparam int EPOCH_W = 3;    // clear generation tag kept with each cell

   localparam logic [DIM_W-1:0]  DIM_MAX    = 11'd1024;
   localparam logic [DATA_W-1:0] CELL_EMPTY = 11'h7FF;   // -1

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PLACE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      HEAD_RIGHT = 2'd0,
      HEAD_DOWN  = 2'd1,
      HEAD_LEFT  = 2'd2,
      HEAD_UP    = 2'd3
   } heading_type;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef struct packed {
      logic restart;
      logic advance;
   } walk_ctrl_type;

endpackage

>>> rtl/smf_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, for a write, a read or both, with registered read data.
// -----------------------------------------------------------------------------
module smf_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic                             rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                 wr_data,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/smf_walk.sv
// -----------------------------------------------------------------------------
// Spiral fill walk
// Holds the four bounds, heading, current position and placement count.
// -----------------------------------------------------------------------------
module smf_walk
   import smf_pkg::*;
#(
   parameter int CNT_W = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  walk_ctrl_type            ctrl,
   input  logic [DIM_W-1:0]         rows,
   input  logic [DIM_W-1:0]         cols,
   output logic signed [WALK_W-1:0] cur_row,
   output logic signed [WALK_W-1:0] cur_col,
   output logic [CNT_W-1:0]         placed
);

   logic signed [WALK_W-1:0] top_ff, top_in;
   logic signed [WALK_W-1:0] bottom_ff, bottom_in;
   logic signed [WALK_W-1:0] left_ff, left_in;
   logic signed [WALK_W-1:0] right_ff, right_in;
   logic signed [WALK_W-1:0] cur_row_ff, cur_row_in;
   logic signed [WALK_W-1:0] cur_col_ff, cur_col_in;
   heading_type              heading_ff, heading_in;
   logic [CNT_W-1:0]         placed_ff, placed_in;

   always_comb begin
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      heading_in = heading_ff;
      placed_in  = placed_ff;
      priority if (ctrl.restart) begin
         top_in     = '0;
         left_in    = '0;
         bottom_in  = $signed({1'b0, rows}) - 12'sd1;
         right_in   = $signed({1'b0, cols}) - 12'sd1;
         cur_row_in = '0;
         cur_col_in = '0;
         heading_in = HEAD_RIGHT;
         placed_in  = '0;
      end else if (ctrl.advance) begin
         placed_in = placed_ff + CNT_W'(1);
         unique case (heading_ff)
            HEAD_RIGHT: begin
               if (cur_col_ff < right_ff) begin
                  cur_col_in = cur_col_ff + 12'sd1;
               end else begin
                  top_in     = top_ff + 12'sd1;
                  heading_in = HEAD_DOWN;
                  cur_row_in = cur_row_ff + 12'sd1;
               end
            end
            HEAD_DOWN: begin
               if (cur_row_ff < bottom_ff) begin
                  cur_row_in = cur_row_ff + 12'sd1;
               end else begin
                  right_in   = right_ff - 12'sd1;
                  heading_in = HEAD_LEFT;
                  cur_col_in = cur_col_ff - 12'sd1;
               end
            end
            HEAD_LEFT: begin
               if (cur_col_ff > left_ff) begin
                  cur_col_in = cur_col_ff - 12'sd1;
               end else begin
                  bottom_in  = bottom_ff - 12'sd1;
                  heading_in = HEAD_UP;
                  cur_row_in = cur_row_ff - 12'sd1;
               end
            end
            HEAD_UP: begin
               if (cur_row_ff > top_ff) begin
                  cur_row_in = cur_row_ff - 12'sd1;
               end else begin
                  left_in    = left_ff + 12'sd1;
                  heading_in = HEAD_RIGHT;
                  cur_col_in = cur_col_ff + 12'sd1;
               end
            end
         endcase
      end else begin
         placed_in = placed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         bottom_ff  <= '0;    // rows reset to 1
         left_ff    <= '0;
         right_ff   <= '0;    // cols reset to 1
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         heading_ff <= HEAD_RIGHT;
         placed_ff  <= '0;
      end else begin
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         heading_ff <= heading_in;
         placed_ff  <= placed_in;
      end
   end

   assign cur_row = cur_row_ff;
   assign cur_col = cur_col_ff;
   assign placed  = placed_ff;

endmodule

>>> rtl/spiral_matrix_fill_top.sv
// -----------------------------------------------------------------------------
// Spiral matrix fill top level
// Clockwise spiral fill of a rows x cols matrix kept in one cell RAM.
// -----------------------------------------------------------------------------
// Items are handled one at a time. A place or read item goes through the
// address multiply, RAM access and result states, a clear item through the
// address, capacity and result states. Each cell carries a 3-bit clear
// generation tag, so a clear only bumps the tag; on every eighth clear, and
// after reset, the RAM is swept to -1 one cell a cycle with no item
// accepted. Register writes take effect at the next clear. The result
// register lets the next item be accepted while a result waits.
// -----------------------------------------------------------------------------
`include "spiral_matrix_fill_top_defines.svh"

module spiral_matrix_fill_top
   import smf_pkg::*;
#(
   parameter int STORE_CELLS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [DIM_W-1:0]  csr_wdata,
   // request items
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,    // value[9:0], row_sel[19:10], col_sel[29:20]
   input  logic [1:0]        req_tuser,    // opcode[1:0]
   // result items
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,    // row[9:0], column[19:10], data[30:20]
   output logic              rsp_tuser     // overflow[0]
);

   localparam int ADDR_W = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
   localparam int CNT_W  = $clog2(STORE_CELLS + 1);
   localparam int WORD_W = EPOCH_W + DATA_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ADDR   = 6'b000010,
      S_ACCESS = 6'b000100,
      S_RESULT = 6'b001000,
      S_CAP    = 6'b010000,
      S_SWEEP  = 6'b100000
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   state_type               state_ff, state_in;
   logic [DIM_W-1:0]        reg_rows_ff, reg_cols_ff;
   logic [DIM_W-1:0]        lat_rows_ff, lat_rows_in;
   logic [DIM_W-1:0]        lat_cols_ff, lat_cols_in;
   logic [EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic [CNT_W-1:0]        capacity_ff, capacity_in;
   logic [ADDR_W-1:0]       sweep_ptr_ff, sweep_ptr_in;

   opcode_type              op_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [POS_W-1:0]        rsel_ff, csel_ff;
   logic [FULL_W-1:0]       addr_ff, addr_in;
   logic                    in_range_ff, in_range_in;
   logic [POS_W-1:0]        res_row_ff, res_row_in;
   logic [POS_W-1:0]        res_col_ff, res_col_in;
   logic                    ovf_ff, ovf_in;
   logic                    hit_ff, hit_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tuser_ff, rsp_tuser_in;

   walk_ctrl_type           walk_ctrl;
   logic signed [WALK_W-1:0] cur_row, cur_col;
   logic [CNT_W-1:0]        placed;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_addr;
   logic [WORD_W-1:0]       ram_wdata, ram_rdata;

   logic [POS_W-1:0]        mul_row, mul_col;
   logic [FULL_W-1:0]       prod;
   logic [2*DIM_W-1:0]      area;
   logic                    full, addr_ok, slot_free, accept;
   logic [DATA_W-1:0]       rd_cell;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign full       = (placed >= capacity_ff);
   assign addr_ok    = (addr_ff < FULL_W'(STORE_CELLS));

   assign mul_row = (op_ff == OP_PLACE) ? cur_row[POS_W-1:0] : rsel_ff;
   assign mul_col = (op_ff == OP_PLACE) ? cur_col[POS_W-1:0] : csel_ff;
   assign prod    = FULL_W'(mul_row) * FULL_W'(lat_cols_ff);
   assign area    = (2*DIM_W)'(lat_rows_ff) * (2*DIM_W)'(lat_cols_ff);

   // stale generation, or a read out of range, reads as an unfilled cell
   assign rd_cell = (hit_ff && (ram_rdata[WORD_W-1:DATA_W] == epoch_ff))
                    ? ram_rdata[DATA_W-1:0] : CELL_EMPTY;

   always_comb begin
      state_in     = state_ff;
      lat_rows_in  = lat_rows_ff;
      lat_cols_in  = lat_cols_ff;
      epoch_in     = epoch_ff;
      capacity_in  = capacity_ff;
      sweep_ptr_in = sweep_ptr_ff;
      addr_in      = addr_ff;
      in_range_in  = in_range_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      ovf_in       = ovf_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      walk_ctrl    = '0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = addr_ff[ADDR_W-1:0];
      ram_wdata    = {epoch_ff, {1'b0, value_ff}};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in     = prod + FULL_W'(mul_col);
            in_range_in = ({1'b0, rsel_ff} < lat_rows_ff) && ({1'b0, csel_ff} < lat_cols_ff);
            if (op_ff == OP_CLEAR) begin
               lat_rows_in       = clamp_dim(reg_rows_ff);
               lat_cols_in       = clamp_dim(reg_cols_ff);
               epoch_in          = epoch_ff + EPOCH_W'(1);
               walk_ctrl.restart = 1'b1;
               state_in          = S_CAP;
            end else begin
               state_in = S_ACCESS;
            end
         end
         S_CAP: begin
            if (area < (2*DIM_W)'(STORE_CELLS)) begin
               capacity_in = CNT_W'(area);
            end else begin
               capacity_in = CNT_W'(STORE_CELLS);
            end
            state_in = S_RESULT;
         end
         S_ACCESS: begin
            res_row_in = '0;
            res_col_in = '0;
            ovf_in     = 1'b0;
            hit_in     = 1'b0;
            if (op_ff == OP_PLACE) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_we            = addr_ok;
                  walk_ctrl.advance = 1'b1;
                  res_row_in        = cur_row[POS_W-1:0];
                  res_col_in        = cur_col[POS_W-1:0];
               end
            end else if (op_ff == OP_READ) begin
               ram_re     = in_range_ff && addr_ok;
               hit_in     = in_range_ff && addr_ok;
               res_row_in = rsel_ff;
               res_col_in = csel_ff;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = 1'b0;
               rsp_tdata_in = '0;
               unique case (op_ff)
                  OP_PLACE: begin
                     rsp_tuser_in = ovf_ff;
                     rsp_tdata_in = {1'b0, (ovf_ff ? DATA_W'(0) : {1'b0, value_ff}),
                                     res_col_ff, res_row_ff};
                  end
                  OP_READ: begin
                     rsp_tdata_in = {1'b0, rd_cell, res_col_ff, res_row_ff};
                  end
                  OP_CLEAR, OP_NONE: begin
                     rsp_tdata_in = '0;
                  end
               endcase
               // tag space wrapped: old tags would alias, wipe the RAM
               if ((op_ff == OP_CLEAR) && (epoch_ff == '0)) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SWEEP: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_ptr_ff;
            ram_wdata = {epoch_ff, CELL_EMPTY};
            if (sweep_ptr_ff == ADDR_W'(STORE_CELLS - 1)) begin
               sweep_ptr_in = '0;
               state_in     = S_IDLE;
            end else begin
               sweep_ptr_in = sweep_ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         reg_rows_ff  <= DIM_W'(1);
         reg_cols_ff  <= DIM_W'(1);
         lat_rows_ff  <= DIM_W'(1);
         lat_cols_ff  <= DIM_W'(1);
         epoch_ff     <= '0;
         capacity_ff  <= CNT_W'(1);
         sweep_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lat_rows_ff  <= lat_rows_in;
         lat_cols_ff  <= lat_cols_in;
         epoch_ff     <= epoch_in;
         capacity_ff  <= capacity_in;
         sweep_ptr_ff <= sweep_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS: reg_rows_ff <= csr_wdata;
               CSR_COLS: reg_cols_ff <= csr_wdata;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= opcode_type'(req_tuser);
         value_ff <= req_tdata[9:0];
         rsel_ff  <= req_tdata[19:10];
         csel_ff  <= req_tdata[29:20];
      end
      addr_ff      <= addr_in;
      in_range_ff  <= in_range_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      ovf_ff       <= ovf_in;
      hit_ff       <= hit_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   smf_walk #(
      .CNT_W (CNT_W)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (walk_ctrl),
      .rows    (lat_rows_in),
      .cols    (lat_cols_in),
      .cur_row (cur_row),
      .cur_col (cur_col),
      .placed  (placed)
   );

   smf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `SMF_ASSERT_NEVER(a_no_rw_clash, clock, reset, ram_we && ram_re)
   `SMF_ASSERT_IMPL(a_place_has_room, clock, reset,
                    ram_we && (state_ff == S_ACCESS), placed < capacity_ff)
   `SMF_ASSERT_NEXT(a_accept_to_addr, clock, reset, accept, state_ff == S_ADDR)
   `SMF_ASSERT_IMPL(a_sweep_on_wrap, clock, reset, state_ff == S_SWEEP, epoch_ff == '0)

endmodule
